// ----- design/sorted_record_table_assert.svh -----
// ---------------------------------------------------------------------------
// sorted_record_table assertion macros
// Shorthands for the concurrent checks of the sorted record table.
// ---------------------------------------------------------------------------
`ifndef SORTED_RECORD_TABLE_ASSERT_SVH
`define SORTED_RECORD_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clock, quiet during reset
`define SRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/srt_pkg.sv -----
// ---------------------------------------------------------------------------
// srt_pkg
// Types and codes shared by the sorted record table modules.
// ---------------------------------------------------------------------------
package srt_pkg;

   // action codes
   localparam logic [2:0] ACT_ADD   = 3'd0;
   localparam logic [2:0] ACT_DEL   = 3'd1;
   localparam logic [2:0] ACT_FIND  = 3'd2;
   localparam logic [2:0] ACT_LIST  = 3'd3;
   localparam logic [2:0] ACT_CLEAR = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   // result word source
   localparam logic [1:0] SRC_ZERO = 2'd0;
   localparam logic [1:0] SRC_ADD  = 2'd1;
   localparam logic [1:0] SRC_CELL = 2'd2;

   // at most this many result words per request
   localparam int MAX_RESULTS = 16;
   localparam logic [3:0] CAP_LAST = 4'(MAX_RESULTS - 1);

   typedef struct packed {
      logic [2:0]  action;
      logic [63:0] first_name;
      logic [63:0] last_name;
      logic [63:0] phone;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] out_first;
      logic [63:0] out_last;
      logic [63:0] out_phone;
      logic [3:0]  position;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0] first_name;
      logic [63:0] last_name;
      logic [63:0] phone;
   } rec_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       compare;
      logic       add;
      logic       del;
      logic       clear;
      logic       scan_start;
      logic       set_hit;
      logic       step;
      logic       emit;
      logic [1:0] emit_src;
      logic [1:0] emit_status;
      logic       emit_last;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] action;
      logic       full;
      logic       empty;
      logic       found;
      logic       hit;
      logic       no_more;
      logic       cap;
   } sts_type;

endpackage

// ----- design/srt_ctrl.sv -----
// ---------------------------------------------------------------------------
// srt_ctrl
// Sequencer for the sorted record table: accepts a request, runs the
// compare, the update or the scan, and hands result words to the output.
// ---------------------------------------------------------------------------
module srt_ctrl import srt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CMP  = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DEL  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = S_CMP;
            end
         end
         S_CMP: begin
            ctl.compare = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            case (sts.action)
               ACT_ADD: begin
                  if (slot_free) begin
                     ctl.emit      = 1'b1;
                     ctl.emit_last = 1'b1;
                     if (sts.full) begin
                        ctl.emit_src    = SRC_ZERO;
                        ctl.emit_status = ST_FULL;
                     end else begin
                        ctl.add         = 1'b1;
                        ctl.emit_src    = SRC_ADD;
                        ctl.emit_status = ST_OK;
                     end
                     state_in = S_IDLE;
                  end
               end
               ACT_DEL: begin
                  if (sts.empty || !sts.found) begin
                     if (slot_free) begin
                        ctl.emit        = 1'b1;
                        ctl.emit_last   = 1'b1;
                        ctl.emit_src    = SRC_ZERO;
                        ctl.emit_status = sts.empty ? ST_EMPTY : ST_NOT_FOUND;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     ctl.set_hit = 1'b1;
                     state_in    = S_DEL;
                  end
               end
               ACT_FIND, ACT_LIST: begin
                  if ((sts.action == ACT_FIND) ? !sts.found : sts.empty) begin
                     if (slot_free) begin
                        ctl.emit        = 1'b1;
                        ctl.emit_last   = 1'b1;
                        ctl.emit_src    = SRC_ZERO;
                        ctl.emit_status = (sts.action == ACT_FIND) ? ST_NOT_FOUND
                                                                    : ST_EMPTY;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     ctl.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               ACT_CLEAR: begin
                  if (slot_free) begin
                     ctl.clear       = 1'b1;
                     ctl.emit        = 1'b1;
                     ctl.emit_last   = 1'b1;
                     ctl.emit_src    = SRC_ZERO;
                     ctl.emit_status = ST_OK;
                     state_in        = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            // one entry per cycle; stall on a hit until the output frees up
            if (!sts.hit) begin
               ctl.step = 1'b1;
            end else if (slot_free) begin
               ctl.emit        = 1'b1;
               ctl.emit_src    = SRC_CELL;
               ctl.emit_status = ST_OK;
               ctl.emit_last   = sts.no_more || sts.cap;
               ctl.step        = 1'b1;
               if (sts.no_more || sts.cap) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DEL: begin
            if (slot_free) begin
               ctl.del         = 1'b1;
               ctl.emit        = 1'b1;
               ctl.emit_src    = SRC_CELL;
               ctl.emit_status = ST_OK;
               ctl.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output word valid
   always_comb begin
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/srt_datapath.sv -----
// ---------------------------------------------------------------------------
// srt_datapath
// Shifting chain of record cells with per-cell compare, the scan pointer
// and the output word register.
// ---------------------------------------------------------------------------
module srt_datapath import srt_pkg::*; #(
   parameter int DEPTH       = 16,
   parameter int NAME_CHARS  = 8,
   parameter int PHONE_CHARS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  ctl_type ctl,
   output sts_type sts,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [63:0] NAME_MASK  = ~(64'hffff_ffff_ffff_ffff >> (8 * NAME_CHARS));
   localparam logic [63:0] PHONE_MASK = ~(64'hffff_ffff_ffff_ffff >> (8 * PHONE_CHARS));

   req_type            req_ff;
   rec_type            cell_ff [DEPTH];
   rec_type            cell_in [DEPTH];
   rec_type            dn_v    [DEPTH];
   rec_type            up_v    [DEPTH];
   rec_type            new_rec;
   rec_type            rd_rec;
   logic [DEPTH-1:0]   ge_ff, mt_ff, ge_in, mt_in, ge_prev, valid_v, sel_v;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   k_ff, k_in, ins_idx, hit_idx;
   logic [3:0]         cnt_ff, cnt_in;
   logic [IDX_W+3:0]   ins_ext, k_ext;
   logic               more;
   rsp_type            rsp_ff, rsp_in;

   assign new_rec = '{first_name: req_ff.first_name, last_name: req_ff.last_name,
                      phone: req_ff.phone};
   assign ge_prev = {ge_ff[DEPTH-2:0], 1'b1};
   assign sel_v   = (req_ff.action == ACT_LIST) ? valid_v : mt_ff;
   assign rd_rec  = cell_ff[k_ff];
   assign ins_ext = {4'b0, ins_idx};
   assign k_ext   = {4'b0, k_ff};

   // per-cell occupancy, compares, neighbors
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         valid_v[i] = (CNT_W'(i) < count_ff);
         ge_in[i]   = valid_v[i] && (cell_ff[i].last_name <= req_ff.last_name);
         mt_in[i]   = valid_v[i] && (cell_ff[i].first_name == req_ff.first_name)
                      && (cell_ff[i].last_name == req_ff.last_name);
         if (i > 0) begin
            dn_v[i] = cell_ff[i-1];
         end else begin
            dn_v[i] = cell_ff[i];
         end
         if (i < DEPTH - 1) begin
            up_v[i] = cell_ff[i+1];
         end else begin
            up_v[i] = cell_ff[i];
         end
      end
   end

   // insert slot, last match, matches beyond the pointer
   always_comb begin
      ins_idx = '0;
      hit_idx = '0;
      more    = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (!ge_ff[i] && ge_prev[i]) begin
            ins_idx = ins_idx | IDX_W'(i);
         end
         if (mt_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
         if ((IDX_W'(i) > k_ff) && sel_v[i]) begin
            more = 1'b1;
         end
      end
   end

   // cell chain update
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_in[i] = cell_ff[i];
         if (ctl.add && !ge_ff[i]) begin
            cell_in[i] = ge_prev[i] ? new_rec : dn_v[i];
         end
         if (ctl.del && (IDX_W'(i) >= k_ff)) begin
            cell_in[i] = up_v[i];
         end
      end
   end

   // count, pointer, word counter
   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.add) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.del) begin
         count_in = count_ff - CNT_W'(1);
      end
      k_in = k_ff;
      if (ctl.scan_start) begin
         k_in = '0;
      end else if (ctl.set_hit) begin
         k_in = hit_idx;
      end else if (ctl.step) begin
         k_in = k_ff + IDX_W'(1);
      end
      cnt_in = cnt_ff;
      if (ctl.scan_start) begin
         cnt_in = '0;
      end else if (ctl.emit && (ctl.emit_src == SRC_CELL)) begin
         cnt_in = cnt_ff + 4'd1;
      end
   end

   // output word
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_in.status = ctl.emit_status;
      rsp_in.last   = ctl.emit_last;
      case (ctl.emit_src)
         SRC_ADD: begin
            rsp_in.out_first = new_rec.first_name;
            rsp_in.out_last  = new_rec.last_name;
            rsp_in.out_phone = new_rec.phone;
            rsp_in.position  = ins_ext[3:0];
         end
         SRC_CELL: begin
            rsp_in.out_first = rd_rec.first_name;
            rsp_in.out_last  = rd_rec.last_name;
            rsp_in.out_phone = rd_rec.phone;
            rsp_in.position  = k_ext[3:0];
         end
         default: begin
            rsp_in.out_first = '0;
            rsp_in.out_last  = '0;
            rsp_in.out_phone = '0;
            rsp_in.position  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         req_ff.action     <= req_data.action;
         req_ff.first_name <= req_data.first_name & NAME_MASK;
         req_ff.last_name  <= req_data.last_name & NAME_MASK;
         req_ff.phone      <= req_data.phone & PHONE_MASK;
      end
      if (ctl.compare) begin
         ge_ff <= ge_in;
         mt_ff <= mt_in;
      end
      if (ctl.emit) begin
         rsp_ff <= rsp_in;
      end
      for (int i = 0; i < DEPTH; i++) begin
         cell_ff[i] <= cell_in[i];
      end
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign sts.action  = req_ff.action;
   assign sts.full    = (count_ff == CNT_W'(DEPTH));
   assign sts.empty   = (count_ff == '0);
   assign sts.found   = |mt_ff;
   assign sts.hit     = sel_v[k_ff];
   assign sts.no_more = !more;
   assign sts.cap     = (cnt_ff == CAP_LAST);
   assign rsp_data    = rsp_ff;

endmodule

// ----- design/sorted_record_table.sv -----
// ---------------------------------------------------------------------------
// sorted_record_table
// Table of records kept in order of last name, with add, delete, find,
// list and clear.
// ---------------------------------------------------------------------------
//  channel | ports              | word
//  --------+--------------------+-------------------------------------
//  request | req_valid/ready    | req_data: action, names, phone
//  result  | rsp_valid/ready    | rsp_data: status, record, position, last
//
// Requests pass the compare and execute states; a delete that hits then
// goes through a delete state. Find and list scan one entry per cycle up
// to the last reported one, holding on a hit while the output is busy.
// Reset empties the table at once; no clearing pass.
// A stalled result channel holds the sequencer before the next word only.
// ---------------------------------------------------------------------------
module sorted_record_table import srt_pkg::*; #(
   parameter int DEPTH       = 16,
   parameter int NAME_CHARS  = 8,
   parameter int PHONE_CHARS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "sorted_record_table_assert.svh"

   ctl_type ctl;
   sts_type sts;

   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   srt_datapath #(
      .DEPTH       (DEPTH),
      .NAME_CHARS  (NAME_CHARS),
      .PHONE_CHARS (PHONE_CHARS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   // checks
   `SRT_ASSERT_NOW(a_emit_slot, ctl.emit, (!rsp_valid || rsp_ready), "word overwritten")
   `SRT_ASSERT_NEXT(a_cmp_after_accept, (req_valid && req_ready), ctl.compare, "no compare")
   `SRT_ASSERT_NOW(a_add_not_full, ctl.add, !sts.full, "insert into full table")
   `SRT_ASSERT_NOW(a_del_not_empty, ctl.del, (!sts.empty && sts.found), "bad delete")

endmodule

// ----- tb/sorted_record_table_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sorted_record_table_checker
// Watches both channels of the sorted record table, keeps its own copy of
// the table, predicts the result words of each accepted request and
// compares them field by field in order.
// ---------------------------------------------------------------------------
module sorted_record_table_checker import srt_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      words_pending
);

   rec_type book [DEPTH];
   int      book_count;
   rsp_type expected_words [$];

   assign words_pending = expected_words.size();

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // queue one predicted word, honoring the per-request cap
   function automatic void push_word(input logic [1:0] st, input int idx,
                                     input bit has, ref int n);
      rsp_type w;
      if (n >= MAX_RESULTS) return;
      w = '0;
      w.status = st;
      if (has) begin
         w.out_first = book[idx].first_name;
         w.out_last  = book[idx].last_name;
         w.out_phone = book[idx].phone;
         w.position  = 4'(idx);
      end
      expected_words.push_back(w);
      n++;
   endfunction

   // apply one request to the shadow table and predict its words
   function automatic void predict_request(input req_type r);
      int n, pos, hit;
      bit found;
      n = 0;
      pos = 0;
      hit = 0;
      found = 0;
      case (r.action)
         ACT_ADD: begin
            if (book_count >= DEPTH) push_word(ST_FULL, 0, 0, n);
            else begin
               while (pos < book_count && book[pos].last_name <= r.last_name) pos++;
               for (int i = book_count; i > pos; i--) book[i] = book[i-1];
               book[pos] = '{r.first_name, r.last_name, r.phone};
               book_count++;
               push_word(ST_OK, pos, 1, n);
            end
         end
         ACT_DEL: begin
            if (book_count == 0) push_word(ST_EMPTY, 0, 0, n);
            else begin
               for (int i = 0; i < book_count; i++)
                  if (book[i].first_name == r.first_name &&
                      book[i].last_name == r.last_name) begin
                     found = 1;
                     hit = i;
                  end
               if (!found) push_word(ST_NOT_FOUND, 0, 0, n);
               else begin
                  push_word(ST_OK, hit, 1, n);
                  for (int i = hit; i + 1 < book_count; i++) book[i] = book[i+1];
                  book_count--;
               end
            end
         end
         ACT_FIND: begin
            for (int i = 0; i < book_count; i++)
               if (book[i].first_name == r.first_name &&
                   book[i].last_name == r.last_name)
                  push_word(ST_OK, i, 1, n);
            if (n == 0) push_word(ST_NOT_FOUND, 0, 0, n);
         end
         ACT_LIST: begin
            for (int i = 0; i < book_count; i++) push_word(ST_OK, i, 1, n);
            if (n == 0) push_word(ST_EMPTY, 0, 0, n);
         end
         ACT_CLEAR: begin
            book_count = 0;
            push_word(ST_OK, 0, 0, n);
         end
         default: ;
      endcase
      if (n > 0) expected_words[$].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         book_count = 0;
         error_count = 0;
         expected_words.delete();
      end else begin
         // results first: a request accepted this edge cannot answer now
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", 64'(rsp_data.status), 64'd0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.out_first !== want.out_first)
                  report_mismatch("out_first", rsp_data.out_first, want.out_first);
               if (rsp_data.out_last !== want.out_last)
                  report_mismatch("out_last", rsp_data.out_last, want.out_last);
               if (rsp_data.out_phone !== want.out_phone)
                  report_mismatch("out_phone", rsp_data.out_phone, want.out_phone);
               if (rsp_data.position !== want.position)
                  report_mismatch("position", 64'(rsp_data.position),
                                  64'(want.position));
               if (rsp_data.last !== want.last)
                  report_mismatch("last", 64'(rsp_data.last), 64'(want.last));
            end
         end
         if (req_valid && req_ready) predict_request(req_data);
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives directed and random add, delete, find, list and clear requests
// into the sorted record table with random gaps on both channels, and
// reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb;
   import srt_pkg::*;

   localparam int DEPTH = 16;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      error_count;
   int      words_pending;

   // small name pool so deletes and finds hit, duplicates included
   logic [63:0] first_pool [4] = '{"Ann", "Bo", "Carl", "Dee"};
   logic [63:0] last_pool  [5] = '{"Adams", "Baker", "Baker", "Cole", "Zed"};

   always #2 clock = ~clock;

   sorted_record_table #(.DEPTH(DEPTH)) DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   sorted_record_table_checker #(.DEPTH(DEPTH)) u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .error_count, .words_pending
   );

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                         : $urandom_range(0, 2);
   endfunction

   // send one word, after a random idle gap when asked, and wait for acceptance
   task automatic send_word(input logic [2:0] act, input logic [63:0] fn,
                            input logic [63:0] ln, input logic [63:0] ph,
                            input bit gaps);
      int g;
      g = gaps ? gap_length() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_data  <= '{act, fn, ln, ph};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [63:0] random_wide();
      return {$urandom, $urandom};
   endfunction

   // result side stalls at random, with quiet stretches
   initial begin
      int g;
      @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         @(negedge clock);
         if ($urandom_range(0, 3) == 0) begin
            g = gap_length();
            if (g > 0) begin
               rsp_ready <= 1'b0;
               repeat (g) @(negedge clock);
            end
         end
      end
   end

   initial begin
      int kind, fi, li;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table cases, extremes, duplicates, full table
      send_word(ACT_DEL, "Ann", "Adams", '0, 0);
      send_word(ACT_FIND, "Ann", "Adams", '0, 0);
      send_word(ACT_LIST, '0, '0, '0, 0);
      send_word(ACT_ADD, '1, '1, '1, 0);
      send_word(ACT_ADD, '0, '0, '0, 0);
      send_word(ACT_ADD, "Bo", "Baker", "5550001", 0);
      send_word(ACT_ADD, "Bo", "Baker", "5550002", 0);
      send_word(ACT_FIND, "Bo", "Baker", '0, 0);
      send_word(ACT_DEL, "Bo", "Baker", '0, 0);
      send_word(ACT_DEL, "Nobody", "Baker", '0, 0);
      send_word(3'd5, '1, '1, '1, 0);
      send_word(3'd7, '0, '0, '0, 0);
      for (int i = 0; i < 15; i++)
         send_word(ACT_ADD, random_wide(), random_wide(), random_wide(), 0);
      send_word(ACT_ADD, "Full", "Table", "0", 0);
      send_word(ACT_LIST, '0, '0, '0, 0);
      send_word(ACT_CLEAR, '0, '0, '0, 0);
      send_word(ACT_LIST, '0, '0, '0, 0);

      // random: adds from the pool most often, with hitting deletes and finds
      for (int n = 0; n < 80; n++) begin
         kind = $urandom_range(0, 99);
         fi = $urandom_range(0, 3);
         li = $urandom_range(0, 4);
         if (kind < 45)
            send_word(ACT_ADD, first_pool[fi], last_pool[li], random_wide(), 1);
         else if (kind < 65)
            send_word(ACT_DEL, first_pool[fi], last_pool[li], random_wide(), 1);
         else if (kind < 80)
            send_word(ACT_FIND, first_pool[fi], last_pool[li], random_wide(), 1);
         else if (kind < 88)
            send_word(ACT_LIST, random_wide(), random_wide(), random_wide(), 1);
         else if (kind < 92)
            send_word(ACT_CLEAR, random_wide(), random_wide(), random_wide(), 1);
         else if (kind < 95)
            send_word(3'($urandom_range(5, 7)), random_wide(), random_wide(),
                      random_wide(), 1);
         else
            send_word(3'($urandom_range(0, 3)), random_wide(), random_wide(),
                      random_wide(), 1);
      end
      req_valid <= 1'b0;

      // drain, then allow the block's own latency to settle
      while (words_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && words_pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/srt_pkg.sv
design/srt_ctrl.sv
design/srt_datapath.sv
design/sorted_record_table.sv
tb/sorted_record_table_checker.sv
tb/tb.sv
